// ----- design/wts_pkg.sv -----
// Shared constants, types and the divider step for the world-to-screen projection.
package wts_pkg;

  localparam int CoordFrac = 16;               // fraction bits of coordinates
  localparam int CoefFrac  = 12;               // fraction bits of coefficients
  localparam int ProdW     = 48;               // 16 x 32 signed product
  localparam int RowW      = 49;               // clip row sum, signed
  localparam int MagW      = 49;               // magnitude of x+w or w-y
  localparam int ScaleW    = 14;               // viewport size
  localparam int NumW      = MagW + ScaleW;    // numerator of the division
  localparam int DivW      = 49;               // divisor 2w
  localparam int QW        = 32;               // quotient bits, one per cell
  localparam int IntBits   = QW - CoordFrac;   // integer bits of the result
  localparam int NumCells  = QW;

  localparam int AddrW = 6;
  localparam logic [2:0] RegRowX   = 3'd0;
  localparam logic [2:0] RegRowY   = 3'd1;
  localparam logic [2:0] RegRowW   = 3'd2;
  localparam logic [2:0] RegWidth  = 3'd3;
  localparam logic [2:0] RegHeight = 3'd4;
  localparam logic [2:0] RegMinDep = 3'd5;

  typedef struct packed {
    logic [DivW-1:0] p;    // partial remainder
    logic [QW-1:0]   lo;   // dividend bits still to bring down
    logic [QW-1:0]   q;    // quotient bits so far
    logic            neg;
    logic            sat;
  } wts_lane_t;

  typedef struct packed {
    wts_lane_t       lx;
    wts_lane_t       ly;
    logic [DivW-1:0] d;
    logic            vis;
  } wts_div_t;

  // One restoring division step: bring down a bit, subtract if it fits.
  function automatic wts_lane_t wts_step(wts_lane_t a, logic [DivW-1:0] d);
    logic [DivW:0] t;
    logic          ge;
    wts_lane_t     r;
    t    = {a.p, a.lo[QW-1]};
    ge   = (t >= {1'b0, d});
    r    = a;
    r.p  = ge ? DivW'(t - {1'b0, d}) : t[DivW-1:0];
    r.lo = {a.lo[QW-2:0], 1'b0};
    r.q  = {a.q[QW-2:0], ge};
    return r;
  endfunction

endpackage

// ----- design/wts_front.sv -----
// Front pipeline: matrix rows, visibility test, numerators and divider set-up.
module wts_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [31:0]               pos_x_i,
  input  logic signed [31:0]               pos_y_i,
  input  logic signed [31:0]               pos_z_i,
  input  logic [63:0]                      row_x_i,
  input  logic [63:0]                      row_y_i,
  input  logic [63:0]                      row_w_i,
  input  logic [wts_pkg::ScaleW-1:0]       width_i,
  input  logic [wts_pkg::ScaleW-1:0]       height_i,
  input  logic [30:0]                      min_depth_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output wts_pkg::wts_div_t                data_o
);

  // stage 1: products
  logic signed [wts_pkg::ProdW-1:0] px_q [3];
  logic signed [wts_pkg::ProdW-1:0] py_q [3];
  logic signed [wts_pkg::ProdW-1:0] pw_q [3];
  logic signed [15:0]               kx_q, ky_q, kw_q;
  // stage 2: rows
  logic signed [wts_pkg::RowW-1:0]  cx_q, cy_q, w_q;
  // stage 3: magnitudes
  logic [wts_pkg::MagW-1:0]         magx_q, magy_q;
  logic                             negx_q, negy_q, vis3_q;
  logic [wts_pkg::DivW-1:0]         d3_q;
  // stage 4: numerators
  logic [wts_pkg::NumW-1:0]         numx_q, numy_q;
  logic                             negx4_q, negy4_q, vis4_q;
  logic [wts_pkg::DivW-1:0]         d4_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  logic signed [31:0] pos [3];
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      for (int k = 0; k < 3; k++) begin
        px_q[k] <= wts_pkg::ProdW'($signed(row_x_i[16*k +: 16])) * wts_pkg::ProdW'(pos[k]);
        py_q[k] <= wts_pkg::ProdW'($signed(row_y_i[16*k +: 16])) * wts_pkg::ProdW'(pos[k]);
        pw_q[k] <= wts_pkg::ProdW'($signed(row_w_i[16*k +: 16])) * wts_pkg::ProdW'(pos[k]);
      end
      kx_q <= $signed(row_x_i[63:48]);
      ky_q <= $signed(row_y_i[63:48]);
      kw_q <= $signed(row_w_i[63:48]);
    end
  end

  // constant term carries the implicit 1.0 in coordinate format
  function automatic logic signed [wts_pkg::RowW-1:0] row_sum(
    logic signed [wts_pkg::ProdW-1:0] a,
    logic signed [wts_pkg::ProdW-1:0] b,
    logic signed [wts_pkg::ProdW-1:0] c,
    logic signed [15:0]               k);
    logic signed [wts_pkg::RowW-1:0] kk;
    kk = wts_pkg::RowW'(k) <<< wts_pkg::CoordFrac;
    return wts_pkg::RowW'(a) + wts_pkg::RowW'(b) + wts_pkg::RowW'(c) + kk;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      cx_q <= row_sum(px_q[0], px_q[1], px_q[2], kx_q);
      cy_q <= row_sum(py_q[0], py_q[1], py_q[2], ky_q);
      w_q  <= row_sum(pw_q[0], pw_q[1], pw_q[2], kw_q);
    end
  end

  logic signed [wts_pkg::RowW:0] nx, ny;
  logic signed [wts_pkg::RowW:0] limit;
  assign nx    = (wts_pkg::RowW+1)'(cx_q) + (wts_pkg::RowW+1)'(w_q);
  assign ny    = (wts_pkg::RowW+1)'(w_q) - (wts_pkg::RowW+1)'(cy_q);
  assign limit = $signed({7'd0, min_depth_i, {wts_pkg::CoefFrac{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      negx_q <= nx[wts_pkg::RowW];
      negy_q <= ny[wts_pkg::RowW];
      magx_q <= wts_pkg::MagW'(nx[wts_pkg::RowW] ? -nx : nx);
      magy_q <= wts_pkg::MagW'(ny[wts_pkg::RowW] ? -ny : ny);
      vis3_q <= (w_q > 0) && ((wts_pkg::RowW+1)'(w_q) >= limit);
      d3_q   <= {w_q[wts_pkg::DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      numx_q  <= wts_pkg::NumW'(magx_q) * wts_pkg::NumW'(width_i);
      numy_q  <= wts_pkg::NumW'(magy_q) * wts_pkg::NumW'(height_i);
      negx4_q <= negx_q;
      negy4_q <= negy_q;
      vis4_q  <= vis3_q;
      d4_q    <= d3_q;
    end
  end

  // Quotient of (num << CoordFrac) / d: the top part starts the remainder,
  // the rest is brought down one bit per cell. Top part >= d overflows.
  function automatic wts_pkg::wts_lane_t lane_init(
    logic [wts_pkg::NumW-1:0] num, logic [wts_pkg::DivW-1:0] d, logic neg);
    wts_pkg::wts_lane_t       l;
    logic [wts_pkg::NumW-1:0] top;
    top   = num >> wts_pkg::IntBits;
    l.p   = top[wts_pkg::DivW-1:0];
    l.lo  = {num[wts_pkg::IntBits-1:0], {wts_pkg::CoordFrac{1'b0}}};
    l.q   = '0;
    l.neg = neg;
    l.sat = (top >= wts_pkg::NumW'(d));
    return l;
  endfunction

  always_comb begin
    data_o.lx  = lane_init(numx_q, d4_q, negx4_q);
    data_o.ly  = lane_init(numy_q, d4_q, negy4_q);
    data_o.d   = d4_q;
    data_o.vis = vis4_q;
  end

endmodule

// ----- design/wts_div_cell.sv -----
// One divider cell: a quotient bit for both screen axes per word.
module wts_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  wts_pkg::wts_div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output wts_pkg::wts_div_t data_o
);

  logic              v_q;
  wts_pkg::wts_div_t data_q;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q.lx  <= wts_pkg::wts_step(data_i.lx, data_i.d);
      data_q.ly  <= wts_pkg::wts_step(data_i.ly, data_i.d);
      data_q.d   <= data_i.d;
      data_q.vis <= data_i.vis;
    end
  end

endmodule

// ----- design/world_to_screen_projection_top.sv -----
// Top level of the world-to-screen projection: registers, divider chain, output.
//
// Use:
//   Input words (pos_x_i, pos_y_i, pos_z_i; signed Q16.16) enter on
//   in_valid_i / in_stall_o; each gives exactly one result word (visible_o,
//   screen_x_o, screen_y_o) on out_valid_o / out_stall_i, in order.
//   The pipeline has 4 front stages (products, row sums, visibility
//   and magnitudes, viewport multiply), 32 divider cells, one output register.
//   Throughput, with out_stall_i low, is one word per cycle; the divider is a
//   row of 32 cells, each taking one quotient bit for both axes, so words march along.
//   When out_stall_i is held, words close up into any empty stages behind the
//   output register; the input is stalled only once every stage is full.
//   Reset empties the pipeline and loads the register defaults (identity-free
//   zero matrix, 1920x1080 viewport, min depth 6554).
//   The APB port (8-byte stride, 64-bit data) must be written only while idle;
//   the block does not enforce this. pready is tied high and reads return the stored values.
module world_to_screen_projection_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      visible_o,
  output logic signed [31:0]        screen_x_o,
  output logic signed [31:0]        screen_y_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wts_pkg::AddrW-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  // ---- configuration registers ----
  logic [63:0]                row_x_q, row_y_q, row_w_q;
  logic [wts_pkg::ScaleW-1:0] width_q, height_q;
  logic [30:0]                min_depth_q;
  logic [2:0]                 reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[wts_pkg::AddrW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q     <= '0;
      row_y_q     <= '0;
      row_w_q     <= '0;
      width_q     <= 14'd1920;
      height_q    <= 14'd1080;
      min_depth_q <= 31'd6554;
    end else if (wr_en) begin
      case (reg_idx)
        wts_pkg::RegRowX:   row_x_q     <= pwdata;
        wts_pkg::RegRowY:   row_y_q     <= pwdata;
        wts_pkg::RegRowW:   row_w_q     <= pwdata;
        wts_pkg::RegWidth:  width_q     <= pwdata[wts_pkg::ScaleW-1:0];
        wts_pkg::RegHeight: height_q    <= pwdata[wts_pkg::ScaleW-1:0];
        wts_pkg::RegMinDep: min_depth_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wts_pkg::RegRowX:   prdata = row_x_q;
      wts_pkg::RegRowY:   prdata = row_y_q;
      wts_pkg::RegRowW:   prdata = row_w_q;
      wts_pkg::RegWidth:  prdata = {50'd0, width_q};
      wts_pkg::RegHeight: prdata = {50'd0, height_q};
      wts_pkg::RegMinDep: prdata = {33'd0, min_depth_q};
      default:            prdata = '0;
    endcase
  end

  // ---- front stages ----
  wts_pkg::wts_div_t chain_d [wts_pkg::NumCells+1];
  logic              chain_v [wts_pkg::NumCells+1];
  logic              chain_r [wts_pkg::NumCells+1];
  logic              front_rdy;

  wts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (front_rdy),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .row_x_i     (row_x_q),
    .row_y_i     (row_y_q),
    .row_w_i     (row_w_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .min_depth_i (min_depth_q),
    .valid_o     (chain_v[0]),
    .ready_i     (chain_r[0]),
    .data_o      (chain_d[0])
  );

  assign in_stall_o = !front_rdy;

  // ---- divider chain: one quotient bit per cell ----
  for (genvar g = 0; g < wts_pkg::NumCells; g++) begin : g_cell
    wts_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[g]),
      .ready_o (chain_r[g]),
      .data_i  (chain_d[g]),
      .valid_o (chain_v[g+1]),
      .ready_i (chain_r[g+1]),
      .data_o  (chain_d[g+1])
    );
  end

  // ---- output register ----
  logic              out_v_q;
  logic              out_en;
  logic              vis_q;
  logic signed [31:0] sx_q, sy_q;

  assign out_en                    = !out_v_q || !out_stall_i;
  assign chain_r[wts_pkg::NumCells] = out_en;

  // sign, saturation and hiding of points behind the near limit
  function automatic logic [31:0] finish(wts_pkg::wts_lane_t l, logic vis);
    logic [31:0] r;
    if (!vis) begin
      r = '0;
    end else if (l.sat) begin
      r = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (l.neg) begin
      r = (l.q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-l.q);
    end else begin
      r = l.q[31] ? 32'h7FFF_FFFF : l.q;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= chain_v[wts_pkg::NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && chain_v[wts_pkg::NumCells]) begin
      vis_q <= chain_d[wts_pkg::NumCells].vis;
      sx_q  <= finish(chain_d[wts_pkg::NumCells].lx, chain_d[wts_pkg::NumCells].vis);
      sy_q  <= finish(chain_d[wts_pkg::NumCells].ly, chain_d[wts_pkg::NumCells].vis);
    end
  end

  assign out_valid_o = out_v_q;
  assign visible_o   = vis_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

`ifndef ASSERT_OFF
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == 32'sd0 && screen_y_o == 32'sd0)
    else $error("hidden point with non-zero screen position");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output register");
`endif

endmodule
